@@ src/nss_pkg.sv @@
// ----------------------------------------------------------------------------
// nss_pkg: shared types and constants for the NCO symbol sampler
// Holds the register map and the command and status bundles that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
package nss_pkg;

  // Configuration register widths.
  localparam int STEP_W     = 24;
  localparam int CARR_W     = 25;
  localparam int WOFF_W     = 16;
  localparam int CFG_DATA_W = 25;
  localparam int CFG_IDX_W  = 2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_STEP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CARRIER_PHASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_OFFSET = 2'd2;

  // Register reset values.
  localparam logic [STEP_W-1:0] STEP_RESET = 24'h100000;
  localparam logic [CARR_W-1:0] CARR_RESET = '0;
  localparam logic [WOFF_W-1:0] WOFF_RESET = '0;

  typedef struct packed {
    logic ld_in;     // capture the accepted input item
    logic seed_mul;  // form window_offset * step
    logic seed_wr;   // write the seeded phase, start the burst
    logic classify;  // remove one turn and pick the mu path
    logic div_step;  // one quotient bit of mu
    logic mul;       // form mu * (previous - current)
    logic emit;      // load the output register
    logic advance;   // store the sample and add the step
  } nss_cmd_t;

  typedef struct packed {
    logic start;     // captured item marks a burst start
    logic active;    // a burst has been seeded
    logic ge_one;    // accumulator has reached one turn
    logic need_div;  // mu needs the iterative divider
    logic out_free;  // output register can take a result
  } nss_sts_t;

endpackage

@@ src/nss_ctrl.sv @@
// ----------------------------------------------------------------------------
// nss_ctrl: sequencing controller of the NCO symbol sampler
// Walks one item at a time through seeding, the divider and the output.
// ----------------------------------------------------------------------------
module nss_ctrl #(
  parameter int PHASE_FRAC_BITS = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  nss_pkg::nss_sts_t sts,
  output nss_pkg::nss_cmd_t cmd
);
  import nss_pkg::*;

  localparam int CNT_W = $clog2(PHASE_FRAC_BITS);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECIDE = 3'd1;
  localparam logic [2:0] ST_SEED   = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_MUL    = 3'd4;
  localparam logic [2:0] ST_OUT    = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             cnt_last;

  assign cnt_last = (cnt_r == CNT_W'(PHASE_FRAC_BITS - 1));
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        priority if (sts.start) begin
          cmd.seed_mul = 1'b1;
          state_nxt    = ST_SEED;
        end else if (!sts.active) begin
          state_nxt = ST_IDLE;
        end else if (!sts.ge_one) begin
          cmd.advance = 1'b1;
          state_nxt   = ST_IDLE;
        end else begin
          cmd.classify = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = sts.need_div ? ST_DIV : ST_MUL;
        end
      end
      ST_SEED: begin
        cmd.seed_wr = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_last) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.emit    = 1'b1;
          cmd.advance = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

@@ src/nss_dpath.sv @@
// ----------------------------------------------------------------------------
// nss_dpath: datapath of the NCO symbol sampler
// Configuration registers, phase accumulator, restoring divider for mu,
// interpolation multiplier and the output register.
// ----------------------------------------------------------------------------
module nss_dpath #(
  parameter int PHASE_FRAC_BITS = 24,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [nss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nss_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic signed [SAMPLE_BITS-1:0]  in_sample,
  input  logic                           in_burst_start,
  input  nss_pkg::nss_cmd_t              cmd,
  output nss_pkg::nss_sts_t              sts,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic signed [SAMPLE_BITS-1:0]  out_soft_symbol,
  output logic                           out_hard_bit
);
  import nss_pkg::*;

  localparam int F   = PHASE_FRAC_BITS;
  localparam int S   = SAMPLE_BITS;
  localparam int AW  = F + 2;
  localparam int UP  = (F > 24) ? F - 24 : 0;
  localparam int DN  = (F < 24) ? 24 - F : 0;
  localparam int SW  = STEP_W + UP;
  localparam int CRW = CARR_W + UP;
  localparam int PW  = F + S + 3;
  localparam int WPW = F + WOFF_W;

  localparam logic [AW-1:0] ONE_A  = {2'b01, {F{1'b0}}};
  localparam logic [F:0]    ONE_MU = {1'b1, {F{1'b0}}};
  localparam logic [F-1:0]  HALF_F = {1'b1, {(F-1){1'b0}}};
  localparam logic [PW-1:0] HALF_P = {{(PW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic [CRW-1:0] DN_BIAS = CRW'((64'd1 << DN) - 64'd1);

  // Configuration and state registers.
  logic [STEP_W-1:0]   step_r;
  logic [CARR_W-1:0]   carr_r;
  logic [WOFF_W-1:0]   woff_r;
  logic [AW-1:0]       acc_r;
  logic [S-1:0]        prev_r;
  logic                active_r;
  logic [S-1:0]        cur_r;
  logic                start_r;
  logic [F-1:0]        wprod_r;
  logic [F:0]          mu_r;
  logic [F-1:0]        rdiv_r;
  logic signed [PW-1:0] mprod_r;
  logic                out_valid_r;
  logic [S-1:0]        soft_r;
  logic                hard_r;

  // Step scaled to the phase format.
  logic [SW-1:0] step_up;
  logic [F-1:0]  st;
  assign step_up = SW'(step_r) << UP;
  assign st      = F'(step_up >> DN);

  // Carrier phase scaled to the phase format, truncating toward zero.
  logic signed [CRW-1:0] cr_up, cr_bias, cr_sc;
  assign cr_up   = CRW'(signed'(carr_r)) <<< UP;
  assign cr_bias = cr_up + (cr_up[CRW-1] ? DN_BIAS : '0);
  assign cr_sc   = cr_bias >>> DN;

  // Only the fraction matters once the seed is wrapped into (0, 1].
  logic [WPW-1:0]      wprod_full;
  logic [F-1:0]        seed_sum;
  logic [AW-1:0]       seed_acc;
  assign wprod_full = WPW'(woff_r) * WPW'(st);
  assign seed_sum   = cr_sc[F-1:0] + HALF_F + st - wprod_r;
  assign seed_acc   = (seed_sum == '0) ? ONE_A : {2'b00, seed_sum};

  // One turn removal and mu path selection.
  logic [AW-1:0] rem;
  logic          st_zero, rem_ge_st;
  assign rem       = acc_r - ONE_A;
  assign st_zero   = (st == '0);
  assign rem_ge_st = (rem >= {2'b00, st});

  // Restoring divider step: the partial remainder stays below the step.
  logic [F:0] r2, rdiff;
  logic       q_bit;
  assign r2    = {rdiv_r, 1'b0};
  assign rdiff = r2 - {1'b0, st};
  assign q_bit = (r2 >= {1'b0, st});

  // Interpolation: current + mu * (previous - current), rounded half up.
  logic signed [F+1:0]  mu_s;
  logic signed [S:0]    diff_s;
  logic signed [PW-1:0] mprod_full, rnd, shd;
  logic [S-1:0]         soft_nxt;
  assign mu_s       = {1'b0, mu_r};
  assign diff_s     = signed'({prev_r[S-1], prev_r}) - signed'({cur_r[S-1], cur_r});
  assign mprod_full = PW'(mu_s) * PW'(diff_s);
  assign rnd        = mprod_r + HALF_P;
  assign shd        = rnd >>> F;
  assign soft_nxt   = cur_r + shd[S-1:0];

  always_comb begin
    sts.start    = start_r;
    sts.active   = active_r;
    sts.ge_one   = (acc_r >= ONE_A);
    sts.need_div = !st_zero && !rem_ge_st;
    sts.out_free = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RESET;
      carr_r <= CARR_RESET;
      woff_r <= WOFF_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SYMBOL_STEP:   step_r <= cfg_data[STEP_W-1:0];
        REG_CARRIER_PHASE: carr_r <= cfg_data[CARR_W-1:0];
        REG_WINDOW_OFFSET: woff_r <= cfg_data[WOFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      prev_r      <= '0;
      active_r    <= 1'b0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.ld_in) begin
        start_r <= in_burst_start;
      end
      if (cmd.seed_wr) begin
        acc_r    <= seed_acc;
        prev_r   <= cur_r;
        active_r <= 1'b1;
      end else if (cmd.classify) begin
        acc_r <= rem;
      end else if (cmd.advance) begin
        acc_r  <= acc_r + {2'b00, st};
        prev_r <= cur_r;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      cur_r <= in_sample;
    end
    if (cmd.seed_mul) begin
      wprod_r <= wprod_full[F-1:0];
    end
    if (cmd.classify) begin
      mu_r   <= (st_zero || !rem_ge_st) ? '0 : ONE_MU;
      rdiv_r <= rem[F-1:0];
    end else if (cmd.div_step) begin
      mu_r   <= {mu_r[F-1:0], q_bit};
      rdiv_r <= q_bit ? rdiff[F-1:0] : r2[F-1:0];
    end
    if (cmd.mul) begin
      mprod_r <= mprod_full;
    end
    if (cmd.emit) begin
      soft_r <= soft_nxt;
      hard_r <= !soft_nxt[S-1] && (soft_nxt != '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_soft_symbol = soft_r;
  assign out_hard_bit    = hard_r;

endmodule

@@ src/nco_symbol_sampler_top.sv @@
// ----------------------------------------------------------------------------
// nco_symbol_sampler_top: burst symbol timing with an NCO clock and
// linear interpolation between neighboring samples.
// ----------------------------------------------------------------------------
// The input channel carries one signed sample per transfer, with
// in_burst_start set on the first sample of a burst. A burst start seeds the
// phase accumulator from carrier_phase, symbol_step and window_offset and
// yields no result. Later samples yield at most one result each: when the
// accumulator has passed one turn, the fraction mu is found by a restoring
// divider and the soft symbol and its hard decision go out on the result
// channel. Samples before the first burst start are dropped.
// One item is worked at a time. A burst start passes the decide and seed
// states, a sample without a symbol only the decide state, and a sample
// with a symbol the decide state, the divider, the multiply and output
// states; the divider, one quotient bit a cycle, is skipped when mu
// saturates or the step is zero. The output register holds a finished
// result while the receiver stalls, and the next item is accepted
// meanwhile; a further result waits in place until the register is free.
// Reset (rst_n low, synchronous) restores the register defaults, clears
// the accumulator, the stored sample and the burst flag.
// Configuration is written through cfg_we, cfg_index and cfg_data.
// ----------------------------------------------------------------------------
module nco_symbol_sampler_top #(
  parameter int PHASE_FRAC_BITS = 24,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [nss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nss_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_BITS-1:0]  in_sample,
  input  logic                           in_burst_start,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_BITS-1:0]  out_soft_symbol,
  output logic                           out_hard_bit
);
  import nss_pkg::*;

  // Commands flow from the controller to the datapath, status flows back.
  nss_cmd_t cmd;
  nss_sts_t sts;

  // The controller sequences each item and owns the input handshake.
  nss_ctrl #(
    .PHASE_FRAC_BITS(PHASE_FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds all arithmetic, the registers and the result stage.
  nss_dpath #(
    .PHASE_FRAC_BITS(PHASE_FRAC_BITS),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_sample      (in_sample),
    .in_burst_start (in_burst_start),
    .cmd            (cmd),
    .sts            (sts),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_soft_symbol(out_soft_symbol),
    .out_hard_bit   (out_hard_bit)
  );

endmodule

@@ src/nss_checker.sv @@
// ----------------------------------------------------------------------------
// nss_checker: port-level checks for the NCO symbol sampler
// Watches the channels of the top level and is attached by a bind.
// ----------------------------------------------------------------------------
module nss_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [SAMPLE_BITS-1:0] out_soft_symbol,
  input logic                          out_hard_bit
);

  // A stalled result stays presented.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && out_valid && out_stall |=> $stable(out_soft_symbol) && $stable(out_hard_bit))
    else $error("result payload changed while stalled");

  // The hard decision matches the sign of the soft symbol.
  a_hard_bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hard_bit == (!out_soft_symbol[SAMPLE_BITS-1] && out_soft_symbol != '0))
    else $error("hard bit disagrees with soft symbol");

  // An accepted sample is worked alone, so the input stalls right after.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_valid && !in_stall |=> in_stall)
    else $error("second transfer accepted while busy");

  // A new result is only produced while an item is being worked.
  a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in work");

endmodule

bind nco_symbol_sampler_top nss_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_nss_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_soft_symbol(out_soft_symbol),
  .out_hard_bit   (out_hard_bit)
);

@@ tb/nss_symbol_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nss_symbol_checker: scoreboard for the NCO symbol sampler
// Watches the configuration port and both channels, keeps its own copy of
// the registers, the clock accumulator and the stored sample, predicts the
// soft symbol and hard bit that each accepted sample causes, and compares
// every result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module nss_symbol_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [nss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nss_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic signed [15:0]             in_sample,
  input  logic                           in_burst_start,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic signed [15:0]             out_soft_symbol,
  input  logic                           out_hard_bit,
  output int                             fail_count,
  output int                             pending,
  output int                             symbols_seen
);
  import nss_pkg::*;

  localparam int               F       = 24;
  localparam int               SW      = 16;
  localparam longint           ONE     = longint'(1) << F;
  localparam logic [F+1:0]     ONE_ACC = (F+2)'(1) << F;
  localparam logic [63:0]      SMP_MAX = (64'd1 << SW) - 64'd1;

  typedef struct packed {
    logic signed [SW-1:0] soft_sym;
    logic                 hard;
  } symbol_t;

  symbol_t           expected_symbols[$];
  logic [STEP_W-1:0] step_r;
  logic [CARR_W-1:0] carr_r;
  logic [WOFF_W-1:0] woff_r;
  logic [F+1:0]      phase_acc;
  logic [SW-1:0]     prev_smp;
  logic              in_burst;
  int                fails;
  int                seen;

  // Starting clock phase of a burst, wrapped into (0, one turn].
  function automatic logic [F+1:0] seed_phase();
    longint p;
    longint r;
    p = longint'($signed(carr_r)) + ONE / 2;
    if (p <= 0) p += ONE;
    p += longint'(step_r);
    p -= longint'(woff_r) * longint'(step_r);
    r = p % ONE;
    if (r <= 0) r += ONE;
    return r[F+1:0];
  endfunction

  // Weighs the stored sample by mu and the current one by 1 - mu, with the
  // arithmetic done in offset binary and rounded half up.
  function automatic symbol_t interpolate(input logic [F+1:0] rem,
                                          input logic [SW-1:0] cur);
    logic [F:0]  mu;
    logic [63:0] up;
    logic [63:0] uc;
    logic [63:0] sum;
    symbol_t     s;
    if (step_r == '0) begin
      mu = '0;
    end else if (rem >= (F+2)'(step_r)) begin
      mu = ONE_ACC[F:0];
    end else begin
      mu = (F+1)'((64'(rem) << F) / 64'(step_r));
    end
    up  = 64'({~prev_smp[SW-1], prev_smp[SW-2:0]});
    uc  = 64'({~cur[SW-1], cur[SW-2:0]});
    sum = 64'(mu) * up + (64'(ONE) - 64'(mu)) * uc + 64'(ONE / 2);
    sum = sum >> F;
    if (sum > SMP_MAX) sum = SMP_MAX;
    s.soft_sym = {~sum[SW-1], sum[SW-2:0]};
    s.hard     = !s.soft_sym[SW-1] && (s.soft_sym != '0);
    return s;
  endfunction

  always @(posedge clk) begin : monitor
    symbol_t got;
    symbol_t want;
    symbol_t pred;
    if (!rst_n) begin
      step_r    = STEP_RESET;
      carr_r    = CARR_RESET;
      woff_r    = WOFF_RESET;
      phase_acc = '0;
      prev_smp  = '0;
      in_burst  = 1'b0;
      fails     = 0;
      seen      = 0;
      expected_symbols.delete();
    end else begin
      // Results first: a result leaving now always belongs to an older sample.
      if (out_valid && !out_stall) begin
        got.soft_sym = out_soft_symbol;
        got.hard     = out_hard_bit;
        if (expected_symbols.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("[%0t] unexpected symbol: soft=%0d hard=%0b",
                     $time, got.soft_sym, got.hard);
        end else begin
          want = expected_symbols.pop_front();
          seen++;
          if (got !== want) begin
            fails++;
            if (fails <= 10)
              $display("[%0t] symbol mismatch: expected %0d/%0b, got %0d/%0b",
                       $time, want.soft_sym, want.hard, got.soft_sym, got.hard);
          end
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_SYMBOL_STEP:   step_r = cfg_data[STEP_W-1:0];
          REG_CARRIER_PHASE: carr_r = cfg_data[CARR_W-1:0];
          REG_WINDOW_OFFSET: woff_r = cfg_data[WOFF_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        if (in_burst_start) begin
          phase_acc = seed_phase();
          prev_smp  = in_sample;
          in_burst  = 1'b1;
        end else if (in_burst) begin
          if (phase_acc >= ONE_ACC) begin
            phase_acc = phase_acc - ONE_ACC;
            pred      = interpolate(phase_acc, in_sample);
            expected_symbols.insert(expected_symbols.size(), pred);
          end
          prev_smp  = in_sample;
          phase_acc = phase_acc + (F+2)'(step_r);
        end
      end
    end
    fail_count   <= fails;
    pending      <= expected_symbols.size();
    symbols_seen <= seen;
  end

endmodule

@@ tb/nco_symbol_sampler_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nco_symbol_sampler_top_tb: stimulus and verdict for the NCO symbol sampler
// Runs a short directed sequence over the sample extremes and the special
// timing cases, then random bursts under several register settings, with
// bursty input pacing and a randomly stalling receiver. Checking is done by
// nss_symbol_checker, which sits beside the block.
// ----------------------------------------------------------------------------
module nco_symbol_sampler_top_tb;
  import nss_pkg::*;

  // Generous bound on the whole run.
  localparam int LIMIT        = 400_000;
  // A sample that yields no symbol may still be in flight when the last
  // expected symbol arrives.
  localparam int SETTLE       = 40;
  localparam int HOLD_CYCLES  = 250;
  localparam int PHASE_ITEMS  = 80;
  localparam int RAND_PHASES  = 10;
  // Index past the end of the register map; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;
  logic                  in_valid       = 1'b0;
  logic                  in_stall;
  logic signed [15:0]    in_sample      = '0;
  logic                  in_burst_start = 1'b0;
  logic                  out_valid;
  logic                  out_stall      = 1'b0;
  logic signed [15:0]    out_soft_symbol;
  logic                  out_hard_bit;

  int   fail_count;
  int   pending;
  int   symbols_seen;
  int   transfers   = 0;
  int   settings    = 0;
  int   burst_left  = 0;
  int   cycle_count = 0;
  bit   no_gaps     = 1'b0;
  logic hold_req    = 1'b0;
  bit   hold_done   = 1'b0;

  nco_symbol_sampler_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .in_burst_start  (in_burst_start),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_soft_symbol (out_soft_symbol),
    .out_hard_bit    (out_hard_bit)
  );

  nss_symbol_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .in_burst_start  (in_burst_start),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_soft_symbol (out_soft_symbol),
    .out_hard_bit    (out_hard_bit),
    .fail_count      (fail_count),
    .pending         (pending),
    .symbols_seen    (symbols_seen)
  );

  always #5 clk = ~clk;

  // Full-scale and near-zero sample values.
  function automatic logic signed [15:0] corner(input int k);
    case (k % 5)
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      3:       return 16'sh0001;
      default: return 16'shFFFF;
    endcase
  endfunction

  // Offers one sample and returns at the edge where the transfer happens.
  // Valid stays high on return so back-to-back samples need no extra edge.
  task automatic push_sample(input logic signed [15:0] smp, input logic first);
    in_valid       <= 1'b1;
    in_sample      <= smp;
    in_burst_start <= first;
    do @(posedge clk); while (in_stall);
    transfers++;
  endtask

  // The sender works in bursts of random length. Between bursts it may drop
  // valid for a random gap, unless the current phase asks for a steady stream.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 20);
      gap        = $urandom_range(0, 6);
      if (gap != 0 && !no_gaps) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // Stops sending and waits until every predicted symbol has come out, then
  // gives the block time to finish a sample that yields no symbol. The first
  // edge lets the checker's count catch up with the last transfer.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes all three registers on consecutive edges, and optionally pokes the
  // unused index with all ones. Only called while the block is idle.
  task automatic program_regs(input logic [STEP_W-1:0] step,
                              input logic [CARR_W-1:0] carr,
                              input logic [WOFF_W-1:0] woff,
                              input bit poke_unused);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SYMBOL_STEP;
    cfg_data  <= CFG_DATA_W'(step);
    @(posedge clk);
    cfg_index <= REG_CARRIER_PHASE;
    cfg_data  <= CFG_DATA_W'(carr);
    @(posedge clk);
    cfg_index <= REG_WINDOW_OFFSET;
    cfg_data  <= CFG_DATA_W'(woff);
    @(posedge clk);
    if (poke_unused) begin
      cfg_index <= REG_UNUSED;
      cfg_data  <= '1;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings++;
  endtask

  // One random phase: a fresh register setting, then a run of samples that
  // mostly continue the current burst, with an occasional new burst start.
  // A phase may also keep the burst from the previous setting running, which
  // is how a shrunken step leaves a remainder at or above the step.
  task automatic run_random_phase(input bit with_hold);
    logic [STEP_W-1:0]  step;
    logic [CARR_W-1:0]  carr;
    logic [WOFF_W-1:0]  woff;
    logic signed [15:0] smp;
    int                 pick;
    int                 c;
    int                 i;
    pick = $urandom_range(0, 9);
    if (with_hold || pick == 2) step = 24'h800000;
    else if (pick == 0) step = '0;
    else if (pick == 1) step = STEP_W'($urandom_range(1, 4096));
    else step = STEP_W'($urandom_range(24'h080000, 24'h800000));

    pick = $urandom_range(0, 4);
    if (pick == 0) c = -8388608;
    else if (pick == 1) c = 8388608;
    else c = int'($urandom_range(0, 16777216)) - 8388608;
    carr = CARR_W'(c);

    pick = $urandom_range(0, 3);
    if (pick == 0) woff = '0;
    else if (pick == 1) woff = '1;
    else if (pick == 2) woff = WOFF_W'($urandom_range(0, 64));
    else woff = WOFF_W'($urandom);

    program_regs(step, carr, woff, 1'b0);
    no_gaps = with_hold;

    if ($urandom_range(0, 3) != 0) begin
      pace();
      push_sample(16'($urandom), 1'b1);
    end
    for (i = 0; i < PHASE_ITEMS; i++) begin
      // Ask for the long receiver hold early in the phase, so the sender
      // keeps offering samples while results back up inside the block.
      if (with_hold && i == 4) hold_req <= 1'b1;
      pace();
      smp = ($urandom_range(0, 7) == 0) ? corner($urandom_range(0, 4)) : 16'($urandom);
      push_sample(smp, $urandom_range(0, 29) == 0);
    end
    drain();
    no_gaps = 1'b0;
  endtask

  // Receiver: stalls in segments of random length, each with its own
  // pattern: never, sparse, heavy or periodic. Once requested, it holds off
  // in one long stretch.
  initial begin : receiver
    int mode;
    int seg;
    int n;
    int tick;
    tick = 0;
    forever begin
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_done = 1'b1;
      end
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(8, 60);
      for (n = 0; n < seg; n++) begin
        if (hold_req && !hold_done) break;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 1) == 1);
          default: out_stall <= ((tick % 4) == 3);
        endcase
        tick++;
        @(posedge clk);
      end
    end
  end

  // Watchdog: ends a hung run.
  initial begin : watchdog
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Watchdog expired after %0d cycles", LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    int k;
    int extra;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Reset setting: samples before any burst start must be
    // dropped, then a burst at a step of one sixteenth that reaches its first
    // symbol on the eighth sample after the start.
    push_sample(corner(0), 1'b0);
    push_sample(corner(1), 1'b0);
    push_sample(corner(2), 1'b0);
    push_sample(corner(1), 1'b1);
    for (k = 0; k < 8; k++) push_sample(corner(k), 1'b0);
    drain();

    // A step and a carrier phase of one half, unused index poked; a new burst start
    // arrives in the middle of a running burst.
    program_regs(24'h800000, 25'h0800000, 16'h0000, 1'b1);
    push_sample(corner(0), 1'b1);
    for (k = 1; k < 5; k++) push_sample(corner(k), 1'b0);
    push_sample(corner(1), 1'b1);
    push_sample(corner(0), 1'b0);
    push_sample(corner(1), 1'b0);
    drain();

    // A step just below one half carries the running burst well past one
    // turn without reaching the test.
    program_regs(24'h7FFFFF, 25'h0800000, 16'h0000, 1'b0);
    push_sample(corner(2), 1'b0);
    push_sample(corner(3), 1'b0);
    drain();

    // Smallest nonzero step, a carrier phase of minus one half and the largest
    // window offset. The burst carries on without a new start, so the remainder
    // left by the large step is not below the new one and mu saturates.
    program_regs(24'd1, 25'h1800000, 16'hFFFF, 1'b0);
    push_sample(corner(0), 1'b0);
    push_sample(corner(1), 1'b0);
    drain();

    // Zero step with a carrier that seeds the accumulator at exactly one
    // turn: the next sample yields a symbol with mu forced to zero.
    program_regs(24'd0, 25'h0800000, 16'h0000, 1'b0);
    push_sample(corner(3), 1'b1);
    push_sample(corner(4), 1'b0);
    drain();

    // Random part. The first phase runs with the long receiver hold and no
    // sender gaps, so the block fills up and stalls its input.
    for (k = 0; k < RAND_PHASES; k++) run_random_phase(k == 0);

    // Keep going while symbols are scarce, e.g. after many small steps.
    extra = 0;
    while (symbols_seen < 48 && extra < 10) begin
      run_random_phase(1'b0);
      extra++;
    end

    $display("Ran %0d sample transfers under %0d register settings with gaps and stalls.",
             transfers, settings);
    $display("Compared %0d interpolated symbols, including zero and saturated mu.",
             symbols_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
